### design/mwbb_pkg.sv
`default_nettype none

package mwbb_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] REG_XROW_A = 3'd0;
   localparam logic [2:0] REG_XROW_B = 3'd1;
   localparam logic [2:0] REG_YROW_A = 3'd2;
   localparam logic [2:0] REG_YROW_B = 3'd3;
   localparam logic [2:0] REG_ZROW_A = 3'd4;
   localparam logic [2:0] REG_ZROW_B = 3'd5;
   localparam logic [2:0] REG_XFORM  = 3'd6;

   localparam logic [63:0] XROW_A_RESET = 64'h0000_0000_3F80_0000;
   localparam logic [63:0] YROW_A_RESET = 64'h3F80_0000_0000_0000;
   localparam logic [63:0] ZROW_B_RESET = 64'h0000_0000_3F80_0000;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

   // Micro-steps of one corner/axis evaluation
   localparam logic [2:0] STEP_MUL_X  = 3'd0;
   localparam logic [2:0] STEP_MUL_Y  = 3'd1;
   localparam logic [2:0] STEP_MUL_Z  = 3'd2;
   localparam logic [2:0] STEP_ADD_XY = 3'd3;
   localparam logic [2:0] STEP_ADD_ZT = 3'd4;
   localparam logic [2:0] STEP_SUM    = 3'd5;

   localparam logic [1:0] AXIS_LAST   = 2'd2;
   localparam logic [2:0] CORNER_LAST = 3'd7;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic        last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] min_x;
      logic [31:0] min_y;
      logic [31:0] min_z;
      logic [31:0] max_x;
      logic [31:0] max_y;
      logic [31:0] max_z;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       issue;
      logic       norm;
      logic       round;
      logic       store;
      logic       emit;
      logic [2:0] step;
      logic [1:0] axis;
      logic [2:0] corner;
   } cmd_type;

   typedef struct packed {
      logic seen_next;
      logic xform;
   } sts_type;

   // Unrounded result: value = mag * 2^expo, unless nan or inf
   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               sign;
      logic [79:0]        mag;
      logic signed [11:0] expo;
   } front_type;

   function automatic logic is_finite(input logic [31:0] a);
      return a[30:23] != 8'hFF;
   endfunction

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
   endfunction

   function automatic logic [7:0] exp_of(input logic [31:0] a);
      return (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
   endfunction

   function automatic logic [23:0] man_of(input logic [31:0] a);
      return {a[30:23] != 8'd0, a[22:0]};
   endfunction

   // Strict less-than; false on NaN, zeros of either sign compare equal
   function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
      logic res;
      if (is_nan(a) || is_nan(b)) begin
         res = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (a[31]) begin
         res = a[30:0] > b[30:0];
      end else begin
         res = a[30:0] < b[30:0];
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_canon(input logic [31:0] a);
      return is_nan(a) ? QNAN_BITS : a;
   endfunction

   function automatic front_type fp_mul_front(input logic [31:0] a, input logic [31:0] b);
      front_type   r;
      logic [47:0] prod;
      prod   = man_of(a) * man_of(b);
      r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && (b[30:0] == 31'd0))
               || (is_inf(b) && (a[30:0] == 31'd0));
      r.inf  = is_inf(a) || is_inf(b);
      r.sign = a[31] ^ b[31];
      r.mag  = {8'd0, prod, 24'd0};
      r.expo = $signed({4'd0, exp_of(a)}) + $signed({4'd0, exp_of(b)}) - 12'sd324;
      return r;
   endfunction

   function automatic front_type fp_add_front(input logic [31:0] a, input logic [31:0] b);
      front_type   r;
      logic [31:0] big;
      logic [31:0] sml;
      logic [7:0]  d;
      logic [5:0]  dd;
      logic [63:0] sfull;
      logic [63:0] sshift;
      logic        stk;
      logic [50:0] sum;
      logic [50:0] sml_al;
      big    = (a[30:0] >= b[30:0]) ? a : b;
      sml    = (a[30:0] >= b[30:0]) ? b : a;
      d      = exp_of(big) - exp_of(sml);
      dd     = (d > 8'd63) ? 6'd63 : d[5:0];
      sfull  = {14'd0, man_of(sml), 26'd0};
      sshift = sfull >> dd;
      stk    = (sshift << dd) != sfull;
      sml_al = {1'b0, sshift[49:1], sshift[0] | stk};
      if (a[31] == b[31]) begin
         sum = {1'b0, man_of(big), 26'd0} + sml_al;
      end else begin
         sum = {1'b0, man_of(big), 26'd0} - sml_al;
      end
      r.nan  = is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]));
      r.inf  = is_inf(a) || is_inf(b);
      r.sign = r.inf ? (is_inf(a) ? a[31] : b[31])
             : ((sum == 51'd0) ? (a[31] & b[31]) : big[31]);
      r.mag  = {5'd0, sum, 24'd0};
      r.expo = $signed({4'd0, exp_of(big)}) - 12'sd200;
      return r;
   endfunction

   function automatic logic [6:0] fp_lead(input logic [79:0] m);
      logic [6:0] p;
      p = 7'd0;
      for (int i = 0; i < 80; i++) begin
         if (m[i]) begin
            p = 7'(i);
         end
      end
      return p;
   endfunction

   // Round to nearest even, subnormals kept
   function automatic logic [31:0] fp_round(input front_type f, input logic [6:0] p);
      logic signed [12:0] lraw;
      logic signed [12:0] lv;
      logic signed [12:0] sv;
      logic signed [12:0] eb;
      logic [6:0]         sh;
      logic [79:0]        lower;
      logic [79:0]        half;
      logic [79:0]        q;
      logic [24:0]        q25;
      logic               guard;
      logic               stk;
      logic [32:0]        val;
      logic [31:0]        res;
      lraw  = $signed({6'd0, p}) + 13'(f.expo) - 13'sd23;
      lv    = (lraw < -13'sd149) ? -13'sd149 : lraw;
      sv    = lv - 13'(f.expo);
      sh    = (sv > 13'sd80) ? 7'd80 : sv[6:0];
      lower = f.mag & ((80'd1 << sh) - 80'd1);
      half  = (sh == 7'd0) ? 80'd0 : (80'd1 << (sh - 7'd1));
      guard = |(f.mag & half);
      stk   = |(lower & ~half);
      q     = f.mag >> sh;
      q25   = q[24:0] + {24'd0, guard & (stk | q[0])};
      eb    = lv + 13'sd149;
      val   = {eb[9:0], 23'd0} + {8'd0, q25};
      if (f.nan) begin
         res = QNAN_BITS;
      end else if (f.inf || (val >= 33'h0_7F80_0000)) begin
         res = {f.sign, 31'h7F80_0000};
      end else if (f.mag == 80'd0) begin
         res = {f.sign, 31'd0};
      end else begin
         res = {f.sign, val[30:0]};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### design/mwbb_ctrl.sv
`default_nettype none

module mwbb_ctrl (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic start,
   input  wire mwbb_pkg::req_type req_data,
   input  wire mwbb_pkg::sts_type sts,
   output      logic          busy,
   output      mwbb_pkg::cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ISSUE = 6'b000010,
      ST_NORM  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_STORE = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] corner_ff, corner_in;
   logic       accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = state_ff != ST_IDLE;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      axis_in   = axis_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.last) begin
               state_in = (sts.seen_next && sts.xform) ? ST_ISSUE : ST_EMIT;
            end
         end
         ST_ISSUE: state_in = ST_NORM;
         ST_NORM:  state_in = ST_ROUND;
         ST_ROUND: state_in = ST_STORE;
         ST_STORE: begin
            state_in = ST_ISSUE;
            if (step_ff != mwbb_pkg::STEP_SUM) begin
               step_in = step_ff + 3'd1;
            end else begin
               step_in = mwbb_pkg::STEP_MUL_X;
               if (axis_ff != mwbb_pkg::AXIS_LAST) begin
                  axis_in = axis_ff + 2'd1;
               end else begin
                  axis_in = 2'd0;
                  if (corner_ff != mwbb_pkg::CORNER_LAST) begin
                     corner_in = corner_ff + 3'd1;
                  end else begin
                     corner_in = 3'd0;
                     state_in  = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= 3'd0;
         axis_ff   <= 2'd0;
         corner_ff <= 3'd0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         axis_ff   <= axis_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      cmd.accept = accept;
      cmd.issue  = state_ff == ST_ISSUE;
      cmd.norm   = state_ff == ST_NORM;
      cmd.round  = state_ff == ST_ROUND;
      cmd.store  = state_ff == ST_STORE;
      cmd.emit   = state_ff == ST_EMIT;
      cmd.step   = step_ff;
      cmd.axis   = axis_ff;
      cmd.corner = corner_ff;
   end

endmodule

`default_nettype wire

### design/mwbb_dp.sv
`default_nettype none

module mwbb_dp (
   input  wire                logic        clock,
   input  wire                logic        reset,
   input  wire mwbb_pkg::cmd_type          cmd,
   input  wire mwbb_pkg::req_type          req_data,
   input  wire                logic        csr_we,
   input  wire                logic [2:0]  csr_index,
   input  wire                logic [63:0] csr_wdata,
   output      mwbb_pkg::sts_type          sts,
   output      logic                       rsp_valid,
   output      mwbb_pkg::rsp_type          rsp_data
);

   logic [63:0] xrow_a_ff, xrow_b_ff, yrow_a_ff, yrow_b_ff, zrow_a_ff, zrow_b_ff;
   logic        xform_ff;
   logic        seen_ff;
   logic [31:0] run_min_ff [3];
   logic [31:0] run_max_ff [3];
   logic [31:0] lo_ff [3];
   logic [31:0] hi_ff [3];
   logic [31:0] s0_ff, s1_ff, s2_ff, u_ff, v_ff;
   mwbb_pkg::front_type front_ff, front_in;
   logic [6:0]  lead_ff;
   logic [31:0] res_ff;
   logic        rsp_valid_ff;
   mwbb_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] pos [3];
   logic        fin;
   logic [63:0] row_a, row_b;
   logic [31:0] px, py, pz;
   logic [31:0] op_a, op_b;

   assign pos[0] = req_data.pos_x;
   assign pos[1] = req_data.pos_y;
   assign pos[2] = req_data.pos_z;
   assign fin = mwbb_pkg::is_finite(pos[0]) && mwbb_pkg::is_finite(pos[1])
                && mwbb_pkg::is_finite(pos[2]);

   assign sts.seen_next = seen_ff || fin;
   assign sts.xform     = xform_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         xrow_a_ff <= mwbb_pkg::XROW_A_RESET;
         xrow_b_ff <= 64'd0;
         yrow_a_ff <= mwbb_pkg::YROW_A_RESET;
         yrow_b_ff <= 64'd0;
         zrow_a_ff <= 64'd0;
         zrow_b_ff <= mwbb_pkg::ZROW_B_RESET;
         xform_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            mwbb_pkg::REG_XROW_A: xrow_a_ff <= csr_wdata;
            mwbb_pkg::REG_XROW_B: xrow_b_ff <= csr_wdata;
            mwbb_pkg::REG_YROW_A: yrow_a_ff <= csr_wdata;
            mwbb_pkg::REG_YROW_B: yrow_b_ff <= csr_wdata;
            mwbb_pkg::REG_ZROW_A: zrow_a_ff <= csr_wdata;
            mwbb_pkg::REG_ZROW_B: zrow_b_ff <= csr_wdata;
            mwbb_pkg::REG_XFORM:  xform_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // running box over the vertex beats
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            run_min_ff[i] <= 32'd0;
            run_max_ff[i] <= 32'd0;
         end
      end else if (cmd.emit) begin
         seen_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            run_min_ff[i] <= 32'd0;
            run_max_ff[i] <= 32'd0;
         end
      end else if (cmd.accept && fin) begin
         seen_ff <= 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (!seen_ff || mwbb_pkg::fp_lt(pos[i], run_min_ff[i])) begin
               run_min_ff[i] <= pos[i];
            end
            if (!seen_ff || mwbb_pkg::fp_lt(run_max_ff[i], pos[i])) begin
               run_max_ff[i] <= pos[i];
            end
         end
      end
   end

   // operand selection for the shared float unit
   always_comb begin
      case (cmd.axis)
         2'd0:    begin row_a = xrow_a_ff; row_b = xrow_b_ff; end
         2'd1:    begin row_a = yrow_a_ff; row_b = yrow_b_ff; end
         default: begin row_a = zrow_a_ff; row_b = zrow_b_ff; end
      endcase
      px = cmd.corner[0] ? run_max_ff[0] : run_min_ff[0];
      py = cmd.corner[1] ? run_max_ff[1] : run_min_ff[1];
      pz = cmd.corner[2] ? run_max_ff[2] : run_min_ff[2];
      unique case (cmd.step)
         mwbb_pkg::STEP_MUL_X:  begin op_a = row_a[31:0];  op_b = px;    end
         mwbb_pkg::STEP_MUL_Y:  begin op_a = row_a[63:32]; op_b = py;    end
         mwbb_pkg::STEP_MUL_Z:  begin op_a = row_b[31:0];  op_b = pz;    end
         mwbb_pkg::STEP_ADD_XY: begin op_a = s0_ff;        op_b = s1_ff; end
         mwbb_pkg::STEP_ADD_ZT: begin op_a = s2_ff;        op_b = row_b[63:32]; end
         default:               begin op_a = u_ff;         op_b = v_ff;  end
      endcase
      if ((cmd.step == mwbb_pkg::STEP_MUL_X) || (cmd.step == mwbb_pkg::STEP_MUL_Y)
          || (cmd.step == mwbb_pkg::STEP_MUL_Z)) begin
         front_in = mwbb_pkg::fp_mul_front(op_a, op_b);
      end else begin
         front_in = mwbb_pkg::fp_add_front(op_a, op_b);
      end
   end

   // float unit: front, leading-one search, round
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         front_ff <= front_in;
      end
      if (cmd.norm) begin
         lead_ff <= mwbb_pkg::fp_lead(front_ff.mag);
      end
      if (cmd.round) begin
         res_ff <= mwbb_pkg::fp_round(front_ff, lead_ff);
      end
   end

   // write back and fold into the world box
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.step)
            mwbb_pkg::STEP_MUL_X:  s0_ff <= res_ff;
            mwbb_pkg::STEP_MUL_Y:  s1_ff <= res_ff;
            mwbb_pkg::STEP_MUL_Z:  s2_ff <= res_ff;
            mwbb_pkg::STEP_ADD_XY: u_ff  <= res_ff;
            mwbb_pkg::STEP_ADD_ZT: v_ff  <= res_ff;
            default: begin
               if ((cmd.corner == 3'd0)
                   || mwbb_pkg::fp_lt(res_ff, lo_ff[cmd.axis])) begin
                  lo_ff[cmd.axis] <= res_ff;
               end
               if ((cmd.corner == 3'd0)
                   || mwbb_pkg::fp_lt(hi_ff[cmd.axis], res_ff)) begin
                  hi_ff[cmd.axis] <= res_ff;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (!seen_ff) begin
         rsp_in = '0;
      end else if (!xform_ff) begin
         rsp_in.found = 1'b1;
         rsp_in.min_x = run_min_ff[0];
         rsp_in.min_y = run_min_ff[1];
         rsp_in.min_z = run_min_ff[2];
         rsp_in.max_x = run_max_ff[0];
         rsp_in.max_y = run_max_ff[1];
         rsp_in.max_z = run_max_ff[2];
      end else begin
         rsp_in.found = 1'b1;
         rsp_in.min_x = mwbb_pkg::fp_canon(lo_ff[0]);
         rsp_in.min_y = mwbb_pkg::fp_canon(lo_ff[1]);
         rsp_in.min_z = mwbb_pkg::fp_canon(lo_ff[2]);
         rsp_in.max_x = mwbb_pkg::fp_canon(hi_ff[0]);
         rsp_in.max_y = mwbb_pkg::fp_canon(hi_ff[1]);
         rsp_in.max_z = mwbb_pkg::fp_canon(hi_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### design/mesh_world_bounding_box.sv
`default_nettype none
// Channel  Ports                              Handshake
// req      start, busy, req_data              beat taken when start && !busy
// rsp      rsp_valid, rsp_data                one-cycle strobe, always taken
// csr      csr_we, csr_index, csr_wdata       write when csr_we
//
// Vertices stream at one per cycle while busy is low. A last beat with the transform
// off, or with no finite vertex, passes through the emit state to the result strobe.
// With the transform on it runs 24 evaluations of six float operations on one shared
// float unit, each operation passing the issue, norm, round and store states. Reset
// is synchronous and restores the identity matrix. The result is not stalled: it
// stands on rsp_data for the one strobe cycle.

module mesh_world_bounding_box (
   input  wire                logic        clock,
   input  wire                logic        reset,
   input  wire                logic        start,
   output      logic                       busy,
   input  wire mwbb_pkg::req_type          req_data,
   output      logic                       rsp_valid,
   output      mwbb_pkg::rsp_type          rsp_data,
   input  wire                logic        csr_we,
   input  wire                logic [2:0]  csr_index,
   input  wire                logic [63:0] csr_wdata
);

   mwbb_pkg::cmd_type cmd;
   mwbb_pkg::sts_type sts;

   mwbb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   mwbb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_emit_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emit without result strobe");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside end of mesh");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.last) |=> busy)
      else $error("last beat did not start the box close");

endmodule

`default_nettype wire
